/* sv/wbps_pkg.sv */
// wbps_pkg: shared types and constants for the wildcard byte signature scanner
// payload structs for both channels, configuration register map and snapshot
// no dependencies
`default_nettype none

package wbps_pkg;

    localparam int ADDR_W     = 64;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int MASK_W     = 16;
    localparam int LEN_W      = 5;
    // signature bytes held by the two pattern registers
    localparam int SIG_BYTES  = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LO   = 3'd0,
        CFG_PAT_HI   = 3'd1,
        CFG_WC_MASK  = 3'd2,
        CFG_PAT_LEN  = 3'd3,
        CFG_BASE     = 3'd4
    } wbps_cfg_idx_e;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       region_end;
    } wbps_in_t;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] match_address;
    } wbps_out_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] pat_lo;
        logic [CFG_DATA_W-1:0] pat_hi;
        logic [MASK_W-1:0]     wc_mask;
        logic [LEN_W-1:0]      pat_len;
        logic [ADDR_W-1:0]     region_base;
    } wbps_cfg_t;

endpackage

`default_nettype wire

/* sv/wbps_cfg_regs.sv */
// wbps_cfg_regs: configuration register file of the signature scanner
// depends on wbps_pkg for the register map and the snapshot struct
`default_nettype none

module wbps_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [wbps_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output wbps_pkg::wbps_cfg_t             cfg_o
);
    import wbps_pkg::*;

    wbps_cfg_t cfg_reg;
    wbps_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (wbps_cfg_idx_e'(cfg_addr))
                CFG_PAT_LO:  cfg_next.pat_lo      = cfg_wdata;
                CFG_PAT_HI:  cfg_next.pat_hi      = cfg_wdata;
                CFG_WC_MASK: cfg_next.wc_mask     = cfg_wdata[MASK_W-1:0];
                CFG_PAT_LEN: cfg_next.pat_len     = cfg_wdata[LEN_W-1:0];
                CFG_BASE:    cfg_next.region_base = cfg_wdata;
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pat_lo      <= '0;
            cfg_reg.pat_hi      <= '0;
            cfg_reg.wc_mask     <= '0;
            cfg_reg.pat_len     <= LEN_W'(1);
            cfg_reg.region_base <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_o = cfg_reg;

endmodule

`default_nettype wire

/* sv/wbps_match.sv */
// wbps_match: parallel compare of the byte window against the wildcard signature
// depends on wbps_pkg for the configuration snapshot
`default_nettype none

module wbps_match #(
    parameter int WIN = 16
) (
    input  logic [7:0]                  win_i [WIN],
    input  wbps_pkg::wbps_cfg_t         cfg_i,
    output logic                        hit_o,
    output logic [wbps_pkg::LEN_W-1:0]  len_m1_o
);
    import wbps_pkg::*;

    logic [LEN_W-1:0]          len_eff;
    logic [2*CFG_DATA_W-1:0]   sig_all;
    logic [WIN-1:0]            byte_ok;

    // zero length counts as one, long lengths clamp to the window
    always_comb begin
        len_eff = cfg_i.pat_len;
        if (cfg_i.pat_len == '0) begin
            len_eff = LEN_W'(1);
        end
        if (cfg_i.pat_len > LEN_W'(WIN)) begin
            len_eff = LEN_W'(WIN);
        end
    end

    assign len_m1_o = len_eff - LEN_W'(1);
    assign sig_all  = {cfg_i.pat_hi, cfg_i.pat_lo};

    // signature byte i lines up with window slot len-1-i (slot 0 is newest)
    always_comb begin
        logic [7:0] sel;
        for (int i = 0; i < WIN; i++) begin
            sel = '0;
            for (int k = 0; k < WIN - i; k++) begin
                if (LEN_W'(k + i) == len_m1_o) begin
                    sel = win_i[k];
                end
            end
            byte_ok[i] = (LEN_W'(i) > len_m1_o) || cfg_i.wc_mask[i]
                         || (sel == sig_all[8*i +: 8]);
        end
    end

    assign hit_o = &byte_ok;

endmodule

`default_nettype wire

/* sv/wildcard_byte_pattern_scan_core.sv */
// wildcard_byte_pattern_scan_core: top level of the wildcard byte signature scanner
// depends on wbps_pkg, wbps_cfg_regs and wbps_match
//
//   port group   dir   handshake          payload
//   cfg_*        in    cfg_we only        cfg_addr, cfg_wdata
//   s_*          in    s_valid/s_ready    s_data (data_byte, region_end)
//   m_*          out   m_valid/m_ready    m_data (found, match_address)
//
// one word per cycle unless the result register stalls: a word is held in the
// input register, then the window shift, compare and address add run in one pass into the result register
// m_valid rises as the word passes into the result register, when the word gives a result
// a stalled result register holds the input register; s_ready drops only then
// reset (aresetn low, synchronous) clears the valid flags and the region state
`default_nettype none

module wildcard_byte_pattern_scan_core #(
    parameter int MAX_PATTERN_BYTES = 16,
    parameter int OFFSET_BITS       = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [wbps_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  wbps_pkg::wbps_in_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output wbps_pkg::wbps_out_t             m_data
);
    import wbps_pkg::*;

    localparam int WIN = (MAX_PATTERN_BYTES < SIG_BYTES) ? MAX_PATTERN_BYTES : SIG_BYTES;
    localparam logic [OFFSET_BITS-1:0] CNT_MAX = '1;

    wbps_cfg_t cfg;

    logic                   in_valid_reg, in_valid_next;
    wbps_in_t               in_data_reg;
    logic [7:0]             win_reg  [WIN];
    logic [7:0]             win_next [WIN];
    logic [OFFSET_BITS-1:0] cnt_reg, cnt_next;
    logic                   match_done_reg, match_done_next;
    logic                   out_valid_reg, out_valid_next;
    wbps_out_t              out_data_reg;
    wbps_out_t              res;

    logic                   proc_go;
    logic                   active;
    logic                   pat_hit;
    logic                   hit;
    logic                   produce;
    logic [LEN_W-1:0]       len_m1;
    logic [OFFSET_BITS-1:0] offset;

    wbps_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg_o     (cfg)
    );

    // word in the input register moves on when the result register can take it
    assign proc_go = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || proc_go;

    always_comb begin
        win_next[0] = in_data_reg.data_byte;
        for (int k = 1; k < WIN; k++) begin
            win_next[k] = win_reg[k-1];
        end
    end

    wbps_match #(.WIN(WIN)) u_match (
        .win_i    (win_next),
        .cfg_i    (cfg),
        .hit_o    (pat_hit),
        .len_m1_o (len_m1)
    );

    // a saturated counter stops shifting and comparing
    assign active  = !match_done_reg && (cnt_reg != CNT_MAX);
    assign hit     = active && (cnt_reg >= OFFSET_BITS'(len_m1)) && pat_hit;
    assign offset  = cnt_reg - OFFSET_BITS'(len_m1);
    assign produce = hit || (in_data_reg.region_end && !match_done_reg);

    always_comb begin
        res.found         = hit;
        res.match_address = hit ? (cfg.region_base + ADDR_W'(offset)) : '0;
    end

    always_comb begin
        in_valid_next   = in_valid_reg;
        cnt_next        = cnt_reg;
        match_done_next = match_done_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        if (proc_go) begin
            in_valid_next  = 1'b0;
            out_valid_next = produce;
            if (active) begin
                cnt_next = cnt_reg + OFFSET_BITS'(1);
            end
            if (hit) begin
                match_done_next = 1'b1;
            end
            if (in_data_reg.region_end) begin
                cnt_next        = '0;
                match_done_next = 1'b0;
            end
        end
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            cnt_reg        <= '0;
            match_done_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg   <= in_valid_next;
            cnt_reg        <= cnt_next;
            match_done_reg <= match_done_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // window slots are only compared once filled in this region, so no clearing
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (proc_go && active) begin
            win_reg <= win_next;
        end
        if (proc_go && produce) begin
            out_data_reg <= res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    a_one_match_per_region: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_go && hit |-> !match_done_reg)
        else $error("second match reported in one region");

    a_done_has_count: assert property (@(posedge aclk) disable iff (!aresetn)
        match_done_reg |-> cnt_reg != '0)
        else $error("match flagged with empty byte count");

    a_region_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_go && in_data_reg.region_end |=> cnt_reg == '0 && !match_done_reg)
        else $error("region state not cleared after last word");

    a_no_lost_result: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |-> !proc_go)
        else $error("pending result overwritten");

endmodule

`default_nettype wire
